// File: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent at one edge requires consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/fmdt_pkg.sv
// shared types and constants of the dual interval timer
// no dependencies
`timescale 1ns / 1ps

package fmdt_pkg;

	localparam int N_TIMERS = 2;
	localparam int TIME_W = 32;
	localparam int KHZ_W = 16;
	localparam int SPAN_W = 9;
	localparam int FACT_W = 12;
	localparam int DIV_W = 14;
	localparam int A_W = KHZ_W + SPAN_W;
	localparam int P_W = A_W + FACT_W;
	localparam int M_W = TIME_W + DIV_W + 1;

	localparam logic [KHZ_W-1:0] KHZ_RESET = 16'd7987;
	localparam logic [DIV_W-1:0] PERIOD_DIV = 14'd10000;
	localparam logic [FACT_W-1:0] FACTOR [N_TIMERS] = '{12'd808, 12'd3231};

	localparam logic [1:0] OP_ADDR = 2'd0;
	localparam logic [1:0] OP_DATA = 2'd1;
	localparam logic [1:0] OP_STATUS = 2'd2;

	localparam logic [7:0] REG_T1_PRESET = 8'd2;
	localparam logic [7:0] REG_T2_PRESET = 8'd3;
	localparam logic [7:0] REG_CONTROL = 8'd4;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CALC1 = 4'b0010,
		ST_CALC2 = 4'b0100,
		ST_DONE  = 4'b1000
	} fmdt_state_t;

	typedef struct packed {
		logic accept_write;
		logic accept_read;
		logic calc1;
		logic calc2;
		logic finish;
	} fmdt_cmd_t;

	typedef struct packed {
		logic is_read;
		logic is_write;
		logic out_blocked;
	} fmdt_sts_t;

endpackage

// File: src/fmdt_ctrl.sv
// sequencing state machine of the dual interval timer
// depends on fmdt_pkg
`timescale 1ns / 1ps

module fmdt_ctrl
	import fmdt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  fmdt_sts_t   sts,
	output fmdt_cmd_t   cmd
);

	fmdt_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.is_write) begin
					cmd.accept_write = 1'b1;
				end
				if (in_valid && sts.is_read) begin
					cmd.accept_read = 1'b1;
					state_nx = ST_CALC1;
				end
			end
			ST_CALC1: begin
				cmd.calc1 = 1'b1;
				state_nx = ST_CALC2;
			end
			ST_CALC2: begin
				cmd.calc2 = 1'b1;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_blocked) begin
					cmd.finish = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// File: src/fmdt_dp.sv
// register file, period multipliers and status register of the dual timer
// depends on fmdt_pkg
`timescale 1ns / 1ps

module fmdt_dp
	import fmdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  fmdt_cmd_t         cmd,
	output fmdt_sts_t         sts,
	input  logic [1:0]        operation,
	input  logic [7:0]        data,
	input  logic [TIME_W-1:0] now,
	input  logic [4:0]        core_low_bits,
	input  logic              cfg_valid,
	input  logic [KHZ_W-1:0]  cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        status
);

	logic [KHZ_W-1:0]  khz_q;
	logic [7:0]        addr_q;
	logic [7:0]        preset_q [N_TIMERS];
	logic [6:0]        control_q;
	logic [N_TIMERS-1:0] run_q;
	logic [N_TIMERS-1:0] exp_q;
	logic [TIME_W-1:0] start_q [N_TIMERS];
	logic [TIME_W-1:0] now_q;
	logic [4:0]        core_q;
	logic [A_W-1:0]    a_s1 [N_TIMERS];
	logic [TIME_W-1:0] e_s1 [N_TIMERS];
	logic [P_W-1:0]    p_s2 [N_TIMERS];
	logic [M_W-1:0]    m_s2 [N_TIMERS];
	logic              out_valid_q;
	logic [7:0]        status_q;
	logic [N_TIMERS-1:0] live;
	logic [N_TIMERS-1:0] hit;
	logic [N_TIMERS-1:0] flag;
	logic [N_TIMERS-1:0] mask;

	assign sts.is_read = (operation == OP_STATUS);
	assign sts.is_write = (operation == OP_ADDR) || (operation == OP_DATA);
	assign sts.out_blocked = out_valid_q && out_stall;

	assign mask = {control_q[5], control_q[6]};

	always_comb begin
		for (int t = 0; t < N_TIMERS; t++) begin
			live[t] = run_q[t] && !mask[t];
			hit[t] = m_s2[t] > M_W'(p_s2[t]);
			flag[t] = live[t] && (exp_q[t] || hit[t]);
		end
	end

	// configuration and register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			khz_q <= KHZ_RESET;
			addr_q <= '0;
			control_q <= '0;
			run_q <= '0;
			exp_q <= '0;
			for (int t = 0; t < N_TIMERS; t++) begin
				preset_q[t] <= '0;
				start_q[t] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				khz_q <= cfg_data;
			end
			if (cmd.accept_write) begin
				unique case (operation)
					OP_ADDR: begin
						addr_q <= data;
					end
					OP_DATA: begin
						unique case (addr_q)
							REG_T1_PRESET: begin
								preset_q[0] <= data;
							end
							REG_T2_PRESET: begin
								preset_q[1] <= data;
							end
							REG_CONTROL: begin
								control_q <= data[6:0];
								if (data[7]) begin
									run_q <= '0;
									exp_q <= '0;
								end else begin
									for (int t = 0; t < N_TIMERS; t++) begin
										if (!control_q[t] && data[t]) begin
											start_q[t] <= now;
											run_q[t] <= 1'b1;
											exp_q[t] <= 1'b0;
										end else if (control_q[t] && !data[t]) begin
											run_q[t] <= 1'b0;
											exp_q[t] <= 1'b0;
										end
									end
								end
							end
							default: begin
							end
						endcase
					end
					default: begin
					end
				endcase
			end
			if (cmd.finish) begin
				for (int t = 0; t < N_TIMERS; t++) begin
					if (live[t] && hit[t]) begin
						exp_q[t] <= 1'b1;
					end
				end
			end
		end
	end

	// status request operands and period arithmetic
	always_ff @(posedge clk) begin
		if (cmd.accept_read) begin
			now_q <= now;
			core_q <= core_low_bits;
		end
		if (cmd.calc1) begin
			for (int t = 0; t < N_TIMERS; t++) begin
				a_s1[t] <= A_W'(khz_q) * A_W'(SPAN_W'(9'd256 - {1'b0, preset_q[t]}));
				e_s1[t] <= now_q - start_q[t];
			end
		end
		if (cmd.calc2) begin
			// expired when (elapsed + 1) * div exceeds the scaled period
			for (int t = 0; t < N_TIMERS; t++) begin
				p_s2[t] <= P_W'(a_s1[t]) * P_W'(FACTOR[t]);
				m_s2[t] <= M_W'(e_s1[t]) * M_W'(PERIOD_DIV) + M_W'(PERIOD_DIV);
			end
		end
		if (cmd.finish) begin
			status_q <= {flag[0] | flag[1], flag[0], flag[1], core_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;

endmodule

// File: src/fm_chip_dual_timer_status.sv
// top level of the dual interval timer with status port
// depends on fmdt_pkg, fmdt_ctrl, fmdt_dp
// address and data writes are taken while idle; a status read passes from
// request to result through two multiplier stages, each followed by a register
// throughput: one write per cycle while idle; input stalls until a read is done
// asynchronous reset clears all timers, presets and control, clock_khz to 7987
`timescale 1ns / 1ps

module fm_chip_dual_timer_status
	import fmdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [7:0]        data,
	input  logic [TIME_W-1:0] now,
	input  logic [4:0]        core_low_bits,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [KHZ_W-1:0]  cfg_data
);

	fmdt_cmd_t cmd;
	fmdt_sts_t sts;

	assign cfg_ready = 1'b1;

	fmdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fmdt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.data          (data),
		.now           (now),
		.core_low_bits (core_low_bits),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status)
	);

endmodule

// File: src/fmdt_checker.sv
// port level checks of the dual interval timer, bound to the top level
// depends on fmdt_pkg, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fmdt_checker
	import fmdt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] operation,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] status
);

	logic rd_acc;
	logic wr_acc;

	assign rd_acc = in_valid && !in_stall && (operation == OP_STATUS);
	assign wr_acc = in_valid && !in_stall && ((operation == OP_ADDR) || (operation == OP_DATA));

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status), "stalled result changed")
	`ASSERT_NEXT(a_read_busy, clk, arst_n, rd_acc, in_stall, "status request did not hold off input")
	`ASSERT_NEXT(a_write_free, clk, arst_n, wr_acc, !in_stall, "write request stalled input")
	`ASSERT_HOLDS(a_any_flag, clk, arst_n, out_valid |-> (status[7] == (status[6] | status[5])), "summary flag mismatch")

endmodule

bind fm_chip_dual_timer_status fmdt_checker u_fmdt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.operation (operation),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status)
);

// File: bench/fm_chip_dual_timer_status_tb.sv
// self-checking bench for the dual interval timer with status port
// drives address, data and status requests and compares every status byte with a timer model
// depends on fmdt_pkg and fm_chip_dual_timer_status
`timescale 1ns / 1ps

module fm_chip_dual_timer_status_tb;
	import fmdt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [7:0] CTL_RUN1 = 8'h01;
	localparam logic [7:0] CTL_RUN2 = 8'h02;
	localparam logic [7:0] CTL_MASK2 = 8'h20;
	localparam logic [7:0] CTL_MASK1 = 8'h40;
	localparam logic [7:0] CTL_CLEAR = 8'h80;
	localparam logic [7:0] CTL_KEEP = 8'h7f;

	localparam logic [7:0] FLAGS_T1 = 8'hc0;
	localparam logic [7:0] FLAGS_T2 = 8'ha0;
	localparam logic [7:0] FLAG_ANY = 8'h80;

	localparam longint unsigned T1_FACTOR = 808;
	localparam longint unsigned T2_FACTOR = 3231;
	localparam longint unsigned PERIOD_DIVISOR = 10000;
	localparam longint unsigned PRESET_SPAN = 256;

	localparam int SETTLE_CYCLES = 8;
	localparam longint unsigned TIMEOUT_NS = 64'd5_000_000;

	class timer_scoreboard;
		logic [15:0] clock_khz;
		logic [7:0] addr_latch;
		logic [7:0] preset [2];
		logic [7:0] control;
		bit running [2];
		bit expired [2];
		logic [31:0] start_stamp [2];
		logic [7:0] expected_status [$];
		int errors;
		int reads_checked;
		int flagged_reads;
		int writes_seen;

		function new();
			clock_khz = KHZ_RESET;
			addr_latch = '0;
			preset[0] = '0;
			preset[1] = '0;
			control = '0;
			for (int t = 0; t < 2; t++) begin
				running[t] = 1'b0;
				expired[t] = 1'b0;
				start_stamp[t] = '0;
			end
			errors = 0;
			reads_checked = 0;
			flagged_reads = 0;
			writes_seen = 0;
		endfunction

		function longint unsigned period(int t);
			longint unsigned factor;
			factor = (t == 0) ? T1_FACTOR : T2_FACTOR;
			return longint'(clock_khz) * (PRESET_SPAN - longint'(preset[t])) * factor
				/ PERIOD_DIVISOR;
		endfunction

		function logic [31:0] deadline(int t);
			longint unsigned span;
			span = period(t);
			return start_stamp[t] + span[31:0];
		endfunction

		function logic [7:0] timer_flags(int t, logic [31:0] stamp);
			logic [31:0] elapsed;
			logic [7:0] mask;
			logic [7:0] flags;
			mask = (t == 0) ? CTL_MASK1 : CTL_MASK2;
			flags = (t == 0) ? FLAGS_T1 : FLAGS_T2;
			if (!running[t] || (control & mask) != 0)
				return '0;
			if (expired[t])
				return flags;
			elapsed = stamp - start_stamp[t];
			if (longint'(elapsed) >= period(t)) begin
				expired[t] = 1'b1;
				return flags;
			end
			return '0;
		endfunction

		function void run_edge(int t, logic [7:0] v, logic [31:0] stamp);
			logic [7:0] run_bit;
			run_bit = (t == 0) ? CTL_RUN1 : CTL_RUN2;
			if ((control & run_bit) == 0 && (v & run_bit) != 0) begin
				start_stamp[t] = stamp;
				running[t] = 1'b1;
				expired[t] = 1'b0;
			end else if ((control & run_bit) != 0 && (v & run_bit) == 0) begin
				running[t] = 1'b0;
				expired[t] = 1'b0;
			end
		endfunction

		function void note_request(logic [1:0] op, logic [7:0] d, logic [31:0] stamp,
				logic [4:0] core);
			logic [7:0] flags;
			case (op)
				OP_ADDR: begin
					addr_latch = d;
					writes_seen++;
				end
				OP_DATA: begin
					writes_seen++;
					if (addr_latch == REG_T1_PRESET) begin
						preset[0] = d;
					end else if (addr_latch == REG_T2_PRESET) begin
						preset[1] = d;
					end else if (addr_latch == REG_CONTROL) begin
						if ((d & CTL_CLEAR) != 0) begin
							for (int t = 0; t < 2; t++) begin
								running[t] = 1'b0;
								expired[t] = 1'b0;
							end
						end else begin
							run_edge(0, d, stamp);
							run_edge(1, d, stamp);
						end
						control = d & CTL_KEEP;
					end
				end
				OP_STATUS: begin
					flags = timer_flags(0, stamp);
					flags = flags | timer_flags(1, stamp);
					expected_status.push_back({3'b000, core} | flags);
				end
				default: ;
			endcase
		endfunction

		function void check_status(logic [7:0] actual);
			logic [7:0] want;
			if (expected_status.size() == 0) begin
				$error("status result with no read pending: actual %02h", actual);
				errors++;
				return;
			end
			want = expected_status.pop_front();
			reads_checked++;
			if ((want & FLAG_ANY) != 0)
				flagged_reads++;
			if (want !== actual) begin
				$error("status mismatch: expected %02h, actual %02h", want, actual);
				errors++;
			end
		endfunction

		function int pending();
			return expected_status.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] operation;
	logic [7:0] data;
	logic [TIME_W-1:0] now;
	logic [4:0] core_low_bits;
	logic out_valid;
	logic out_stall;
	logic [7:0] status;
	logic cfg_valid;
	logic cfg_ready;
	logic [KHZ_W-1:0] cfg_data;

	timer_scoreboard sb;
	bit calm;
	int settings_used;

	fm_chip_dual_timer_status i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.data(data),
		.now(now),
		.core_low_bits(core_low_bits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_request(input logic [1:0] op, input logic [7:0] d,
			input logic [31:0] stamp, input logic [4:0] core);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data <= d;
		now <= stamp;
		core_low_bits <= core;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_request(op, d, stamp, core);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_clock_khz(input logic [15:0] khz);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= khz;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.clock_khz = khz;
		settings_used++;
		cfg_valid <= 1'b0;
	endtask

	task automatic directed_requests();
		send_request(OP_UNUSED, 8'hff, 32'hffff_ffff, 5'h1f);
		send_request(OP_STATUS, 8'h00, 32'h0000_0000, 5'h1f);
		send_request(OP_ADDR, REG_T1_PRESET, 32'h0, 5'h00);
		send_request(OP_DATA, 8'h00, 32'h0, 5'h00);
		send_request(OP_ADDR, REG_T2_PRESET, 32'h0, 5'h00);
		send_request(OP_DATA, 8'hff, 32'h0, 5'h00);
		send_request(OP_ADDR, REG_CONTROL, 32'h0, 5'h00);
		// start both timers just before the count wraps
		send_request(OP_DATA, CTL_RUN1 | CTL_RUN2, 32'hffff_fff0, 5'h00);
		send_request(OP_STATUS, 8'h00, sb.deadline(1) - 32'd1, 5'h00);
		send_request(OP_STATUS, 8'h00, sb.deadline(1), 5'h15);
		send_request(OP_STATUS, 8'h00, sb.deadline(0) - 32'd1, 5'h0a);
		send_request(OP_STATUS, 8'h00, sb.deadline(0), 5'h00);
		// masked timers hide their latched flags
		send_request(OP_DATA, CTL_MASK1 | CTL_MASK2 | CTL_RUN1 | CTL_RUN2, 32'h0, 5'h00);
		send_request(OP_STATUS, 8'h00, sb.deadline(0), 5'h1f);
		send_request(OP_DATA, CTL_RUN1 | CTL_RUN2, 32'h0, 5'h00);
		send_request(OP_STATUS, 8'h00, 32'h0000_0000, 5'h00);
		// clear stops both, then a held run bit gives no new start
		send_request(OP_DATA, CTL_CLEAR | CTL_RUN1, 32'h1234_5678, 5'h00);
		send_request(OP_STATUS, 8'h00, 32'hffff_ffff, 5'h00);
		send_request(OP_DATA, 8'h00, 32'h0, 5'h00);
		send_request(OP_DATA, CTL_RUN2, 32'h8000_0000, 5'h00);
		send_request(OP_STATUS, 8'h00, sb.deadline(1), 5'h00);
		send_request(OP_ADDR, 8'h84, 32'h0, 5'h00);
		send_request(OP_DATA, 8'h55, 32'h0, 5'h00);
		send_request(OP_UNUSED, 8'h00, 32'h0, 5'h00);
		send_request(OP_STATUS, 8'h00, sb.deadline(1) + 32'd7, 5'h0f);
	endtask

	task automatic random_phase(input int target);
		int counted;
		int iter;
		int pick;
		int t;
		logic [7:0] v;
		logic [31:0] stamp;
		counted = 0;
		iter = 0;
		while (counted < target) begin
			if (iter % 48 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) == 0)
				drain_results();
			iter++;
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				t = $urandom_range(0, 1);
				stamp = sb.deadline(t) + 32'($urandom_range(0, 6)) - 32'd3;
				send_request(OP_STATUS, 8'($urandom), stamp, 5'($urandom));
				counted++;
			end else if (pick < 45) begin
				send_request(OP_STATUS, 8'($urandom), $urandom, 5'($urandom));
				counted++;
			end else if (pick < 60) begin
				v = 8'($urandom);
				if ($urandom_range(0, 3) == 0)
					v = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
				send_request(OP_ADDR, ($urandom_range(0, 1) == 0) ? REG_T1_PRESET :
					REG_T2_PRESET, $urandom, 5'($urandom));
				send_request(OP_DATA, v, $urandom, 5'($urandom));
				counted += 2;
			end else if (pick < 85) begin
				v = 8'($urandom) & ~(CTL_CLEAR | CTL_MASK1 | CTL_MASK2);
				if ($urandom_range(0, 7) == 0)
					v = v | CTL_CLEAR;
				if ($urandom_range(0, 3) == 0)
					v = v | CTL_MASK1;
				if ($urandom_range(0, 3) == 0)
					v = v | CTL_MASK2;
				send_request(OP_ADDR, REG_CONTROL, $urandom, 5'($urandom));
				send_request(OP_DATA, v, $urandom, 5'($urandom));
				counted += 2;
			end else if (pick < 93) begin
				send_request(OP_DATA, 8'($urandom), $urandom, 5'($urandom));
				counted++;
			end else if (pick < 97) begin
				send_request(OP_ADDR, 8'($urandom), $urandom, 5'($urandom));
			end else begin
				send_request(OP_UNUSED, 8'($urandom), $urandom, 5'($urandom));
			end
		end
	endtask

	// result side: random stall before each accepted status
	initial begin
		int hold;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_status(status);
		end
	end

	initial begin
		logic [15:0] khz;
		sb = new();
		calm = 1'b0;
		settings_used = 1;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_ADDR;
		data <= '0;
		now <= '0;
		core_low_bits <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_requests();
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 1)
				khz = 16'd1;
			else if (phase == 2)
				khz = 16'd65535;
			else if (phase == 5)
				khz = KHZ_RESET;
			else
				khz = 16'($urandom_range(1, 65535));
			if (phase > 0)
				write_clock_khz(khz);
			random_phase(300);
		end
		drain_results();
		if (sb.pending() != 0) begin
			$error("%0d status results never arrived", sb.pending());
			sb.errors++;
		end
		$display("checked %0d status reads, %0d of them flagged, after %0d writes",
			sb.reads_checked, sb.flagged_reads, sb.writes_seen);
		$display("clock_khz took %0d settings including 1 and 65535", settings_used);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d status results outstanding", sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
